### rtl/idq_pkg.sv
// Shared types and constants for the indexed deque engine.
package idq_pkg;

    localparam int CMD_W  = 3;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_READ   = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_INSERT = 3'd4,
        CMD_ERASE  = 3'd5,
        CMD_FIND   = 3'd6,
        CMD_CLEAR  = 3'd7
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_FULL     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MOVE,
        S_PUT,
        S_FIND,
        S_DONE
    } state_t;

    typedef struct packed {
        status_t           status;
        logic [VAL_W-1:0]  data;
        logic [IDX_W-1:0]  found_index;
        logic [CNT_W-1:0]  count;
    } res_t;

endpackage

### rtl/idq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module idq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/idq_ctrl.sv
// Command sequencer: pointers, shift walk, search walk and result capture.
module idq_ctrl #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [idq_pkg::CMD_W-1:0]     s_cmd,
    input  logic [idq_pkg::IDX_W-1:0]     s_index,
    input  logic [idq_pkg::VAL_W-1:0]     s_value,
    input  logic                          out_free,
    output logic                          res_load,
    output idq_pkg::res_t                 res,
    output logic                          mem_wr_en,
    output logic [AW-1:0]                 mem_wr_addr,
    output logic [idq_pkg::VAL_W-1:0]     mem_wr_data,
    output logic                          mem_rd_en,
    output logic [AW-1:0]                 mem_rd_addr,
    input  logic [idq_pkg::VAL_W-1:0]     mem_rd_data
);

    localparam int CMPW = (CW > idq_pkg::IDX_W) ? CW : idq_pkg::IDX_W;
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        return (a == LAST) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
        return (a == '0) ? LAST : a - 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_step(input logic [AW-1:0] a, input logic up);
        return up ? ring_inc(a) : ring_dec(a);
    endfunction

    idq_pkg::state_t               state_reg, state_next;
    logic [AW-1:0]                 front_reg, front_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [idq_pkg::VAL_W-1:0]     val_reg, val_next;
    logic [AW-1:0]                 dst_reg, dst_next;
    logic                          up_reg, up_next;
    logic [CW-1:0]                 rem_reg, rem_next;
    logic [AW-1:0]                 put_reg, put_next;
    logic                          put_en_reg, put_en_next;
    logic                          pend_reg, pend_next;
    logic [AW-1:0]                 pend_dst_reg, pend_dst_next;
    logic [AW-1:0]                 pend_idx_reg, pend_idx_next;
    logic [AW-1:0]                 scan_ptr_reg, scan_ptr_next;
    logic [CW-1:0]                 scan_left_reg, scan_left_next;
    logic [AW-1:0]                 scan_idx_reg, scan_idx_next;
    idq_pkg::status_t              res_status_reg, res_status_next;
    logic [idq_pkg::VAL_W-1:0]     res_data_reg, res_data_next;
    logic [idq_pkg::IDX_W-1:0]     res_found_reg, res_found_next;

    idq_pkg::cmd_t     cmd;
    logic [CMPW-1:0]   idx_x;
    logic [CMPW-1:0]   cnt_x;
    logic              in_range;
    logic              is_full;
    logic              is_empty;
    logic              front_side;
    logic [AW-1:0]     idx_a;
    logic [CW-1:0]     idx_c;
    logic [AW-1:0]     cnt_a;
    logic [AW-1:0]     slot_idx;
    logic [AW-1:0]     slot_end;
    logic [AW-1:0]     front_dn;
    logic              hit;

    assign cmd        = idq_pkg::cmd_t'(s_cmd);
    assign idx_x      = CMPW'(s_index);
    assign cnt_x      = CMPW'(count_reg);
    assign in_range   = idx_x < cnt_x;
    assign is_full    = count_reg == DEPTH_C;
    assign is_empty   = count_reg == '0;
    assign front_side = idx_x <= (cnt_x >> 1);
    assign idx_a      = AW'(s_index);
    assign idx_c      = CW'(s_index);
    assign cnt_a      = AW'(count_reg);
    assign slot_idx   = ring_add(front_reg, idx_a);
    assign slot_end   = ring_add(front_reg, cnt_a);
    assign front_dn   = ring_dec(front_reg);
    assign hit        = pend_reg && (mem_rd_data == val_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            idq_pkg::S_IDLE: begin
                if (s_valid) begin
                    case (cmd)
                        idq_pkg::CMD_READ:
                            state_next = in_range ? idq_pkg::S_READ : idq_pkg::S_DONE;
                        idq_pkg::CMD_INSERT:
                            state_next = (in_range && !is_full) ? idq_pkg::S_MOVE
                                                                : idq_pkg::S_DONE;
                        idq_pkg::CMD_ERASE:
                            state_next = in_range ? idq_pkg::S_MOVE : idq_pkg::S_DONE;
                        idq_pkg::CMD_FIND:
                            state_next = !is_empty ? idq_pkg::S_FIND : idq_pkg::S_DONE;
                        default:
                            state_next = idq_pkg::S_DONE;
                    endcase
                end
            end
            idq_pkg::S_READ: state_next = idq_pkg::S_DONE;
            idq_pkg::S_MOVE: begin
                if (rem_reg == '0 && !pend_reg) begin
                    state_next = put_en_reg ? idq_pkg::S_PUT : idq_pkg::S_DONE;
                end
            end
            idq_pkg::S_PUT: state_next = idq_pkg::S_DONE;
            idq_pkg::S_FIND: begin
                if (hit || (scan_left_reg == '0 && !pend_reg)) begin
                    state_next = idq_pkg::S_DONE;
                end
            end
            idq_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = idq_pkg::S_IDLE;
                end
            end
            default: state_next = idq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        front_next      = front_reg;
        count_next      = count_reg;
        val_next        = val_reg;
        dst_next        = dst_reg;
        up_next         = up_reg;
        rem_next        = rem_reg;
        put_next        = put_reg;
        put_en_next     = put_en_reg;
        pend_next       = 1'b0;
        pend_dst_next   = pend_dst_reg;
        pend_idx_next   = pend_idx_reg;
        scan_ptr_next   = scan_ptr_reg;
        scan_left_next  = scan_left_reg;
        scan_idx_next   = scan_idx_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_found_next  = res_found_reg;
        s_ready         = 1'b0;
        res_load        = 1'b0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = dst_reg;
        mem_wr_data     = val_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = dst_reg;

        case (state_reg)
            idq_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    val_next        = s_value;
                    res_status_next = idq_pkg::STAT_OK;
                    res_data_next   = '0;
                    res_found_next  = '0;
                    case (cmd)
                        idq_pkg::CMD_PUSH: begin
                            if (is_full) begin
                                res_status_next = idq_pkg::STAT_FULL;
                            end else begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = slot_end;
                                mem_wr_data = s_value;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        idq_pkg::CMD_POP: begin
                            if (is_empty) begin
                                res_status_next = idq_pkg::STAT_EMPTY;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        idq_pkg::CMD_READ: begin
                            if (!in_range) begin
                                res_status_next = idq_pkg::STAT_RANGE;
                            end else begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = slot_idx;
                            end
                        end
                        idq_pkg::CMD_WRITE: begin
                            if (!in_range) begin
                                res_status_next = idq_pkg::STAT_RANGE;
                            end else begin
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = slot_idx;
                                mem_wr_data = s_value;
                            end
                        end
                        idq_pkg::CMD_INSERT: begin
                            if (!in_range) begin
                                res_status_next = idq_pkg::STAT_RANGE;
                            end else if (is_full) begin
                                res_status_next = idq_pkg::STAT_FULL;
                            end else begin
                                count_next  = count_reg + 1'b1;
                                put_en_next = 1'b1;
                                if (front_side) begin
                                    front_next = front_dn;
                                    dst_next   = front_dn;
                                    up_next    = 1'b1;
                                    rem_next   = idx_c;
                                    put_next   = ring_add(front_dn, idx_a);
                                end else begin
                                    dst_next = slot_end;
                                    up_next  = 1'b0;
                                    rem_next = count_reg - idx_c;
                                    put_next = slot_idx;
                                end
                            end
                        end
                        idq_pkg::CMD_ERASE: begin
                            if (!in_range) begin
                                res_status_next = idq_pkg::STAT_RANGE;
                            end else begin
                                count_next  = count_reg - 1'b1;
                                put_en_next = 1'b0;
                                dst_next    = slot_idx;
                                if (front_side) begin
                                    front_next = ring_inc(front_reg);
                                    up_next    = 1'b0;
                                    rem_next   = idx_c;
                                end else begin
                                    up_next  = 1'b1;
                                    rem_next = count_reg - idx_c - 1'b1;
                                end
                            end
                        end
                        idq_pkg::CMD_FIND: begin
                            if (is_empty) begin
                                res_status_next = idq_pkg::STAT_NOTFOUND;
                            end else begin
                                scan_ptr_next  = front_reg;
                                scan_left_next = count_reg;
                                scan_idx_next  = '0;
                            end
                        end
                        default: begin
                            count_next = '0;
                            front_next = '0;
                        end
                    endcase
                end
            end
            idq_pkg::S_READ: begin
                res_data_next = mem_rd_data;
            end
            idq_pkg::S_MOVE: begin
                if (rem_reg != '0) begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = ring_step(dst_reg, up_reg);
                    pend_next     = 1'b1;
                    pend_dst_next = dst_reg;
                    dst_next      = ring_step(dst_reg, up_reg);
                    rem_next      = rem_reg - 1'b1;
                end
                if (pend_reg) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pend_dst_reg;
                    mem_wr_data = mem_rd_data;
                end
            end
            idq_pkg::S_PUT: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = put_reg;
                mem_wr_data = val_reg;
            end
            idq_pkg::S_FIND: begin
                if (hit) begin
                    res_status_next = idq_pkg::STAT_OK;
                    res_found_next  = idq_pkg::IDX_W'(pend_idx_reg);
                end else if (scan_left_reg != '0) begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = scan_ptr_reg;
                    pend_next      = 1'b1;
                    pend_idx_next  = scan_idx_reg;
                    scan_ptr_next  = ring_inc(scan_ptr_reg);
                    scan_left_next = scan_left_reg - 1'b1;
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end else if (!pend_reg) begin
                    res_status_next = idq_pkg::STAT_NOTFOUND;
                end
            end
            idq_pkg::S_DONE: begin
                res_load = out_free;
            end
            default: begin
                res_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= idq_pkg::S_IDLE;
            front_reg  <= '0;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            put_en_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            put_en_reg <= put_en_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg        <= val_next;
        dst_reg        <= dst_next;
        up_reg         <= up_next;
        rem_reg        <= rem_next;
        put_reg        <= put_next;
        pend_dst_reg   <= pend_dst_next;
        pend_idx_reg   <= pend_idx_next;
        scan_ptr_reg   <= scan_ptr_next;
        scan_left_reg  <= scan_left_next;
        scan_idx_reg   <= scan_idx_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_found_reg  <= res_found_next;
    end

    assign res.status      = res_status_reg;
    assign res.data        = res_data_reg;
    assign res.found_index = res_found_reg;
    assign res.count       = idq_pkg::CNT_W'(count_reg);

endmodule

### rtl/indexed_deque_engine.sv
// Top level of the indexed deque engine: sequencer, element RAM and result register.
//
// Holds an ordered sequence of up to DEPTH signed 32-bit words in a ring kept in one
// RAM with a registered read; each command gives exactly one result. One item is
// worked at a time and a finished result waits in the output register while the next
// item is taken. Push, pop, write, clear and every error case go from idle straight to
// the done state; read passes through a read state first. Insert and erase move one
// side of the sequence one entry per cycle through the RAM: the front side when the
// index is at most count/2, else the back side. An insert moves index entries on the
// front side and count - index on the back side, then writes the new value. An erase
// moves index entries on the front side and count - index - 1 on the back side. Both
// move at most DEPTH/2 entries. Find walks the entries from the front one per cycle
// and stops at the first match, or after all count entries when nothing matches. No
// clearing pass follows reset: entries outside the live range are never read.
module indexed_deque_engine #(
    parameter int DEPTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [idq_pkg::CMD_W-1:0]         s_cmd,
    input  logic [idq_pkg::IDX_W-1:0]         s_index,
    input  logic signed [idq_pkg::VAL_W-1:0]  s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [idq_pkg::STAT_W-1:0]        m_status,
    output logic signed [idq_pkg::VAL_W-1:0]  m_data,
    output logic [idq_pkg::IDX_W-1:0]         m_found_index,
    output logic [idq_pkg::CNT_W-1:0]         m_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                          out_free;
    logic                          res_load;
    idq_pkg::res_t                 res;
    logic                          mem_wr_en;
    logic [AW-1:0]                 mem_wr_addr;
    logic [idq_pkg::VAL_W-1:0]     mem_wr_data;
    logic                          mem_rd_en;
    logic [AW-1:0]                 mem_rd_addr;
    logic [idq_pkg::VAL_W-1:0]     mem_rd_data;

    logic                          m_valid_reg, m_valid_next;
    idq_pkg::res_t                 m_res_reg, m_res_next;

    idq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_index     (s_index),
        .s_value     (s_value),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    idq_ram #(
        .WIDTH (idq_pkg::VAL_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_res_reg.status;
    assign m_data        = m_res_reg.data;
    assign m_found_index = m_res_reg.found_index;
    assign m_count       = m_res_reg.count;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != idq_pkg::STAT_OK) |-> (m_data == '0))
        else $error("data not zero on a failed command");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == idq_pkg::STAT_NOTFOUND) |-> (m_found_index == '0))
        else $error("found index not zero on a failed find");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == idq_pkg::STAT_EMPTY) |-> (m_count == '0))
        else $error("empty status with nonzero count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == idq_pkg::STAT_FULL) |-> (m_count == idq_pkg::CNT_W'(DEPTH)))
        else $error("full status with count below depth");

endmodule
